/* design/dsd_pkg.sv */
package dsd_pkg;

  // Field widths fixed by the stream format.
  localparam int unsigned FIELD_W  = 24;
  localparam int unsigned WORD_W   = 32;
  localparam int unsigned BYTE_W   = 8;

  // Default for the number of header bits that carry the message length.
  localparam int unsigned LENGTH_BITS_DEF = 24;

  // Header size in bytes, and the index of its last byte.
  localparam logic [FIELD_W-1:0] HEADER_BYTES = 24'd4;
  localparam logic [FIELD_W-1:0] HEADER_LAST  = 24'd3;

  // Length limit reset values.
  localparam logic [FIELD_W-1:0] MIN_LENGTH_RST = 24'd20;
  localparam logic [FIELD_W-1:0] MAX_LENGTH_RST = 24'd65535;

  // Configuration register indexes.
  localparam logic CFG_MIN_LENGTH = 1'b0;
  localparam logic CFG_MAX_LENGTH = 1'b1;

  // Result kinds.
  typedef enum logic [1:0] {
    KIND_HEADER = 2'd0,
    KIND_BODY   = 2'd1,
    KIND_ERROR  = 2'd2,
    KIND_CLOSED = 2'd3
  } kind_t;

  // One result beat.
  typedef struct packed {
    kind_t               kind;
    logic [WORD_W-1:0]   header_word;
    logic [BYTE_W-1:0]   body_byte;
    logic [FIELD_W-1:0]  byte_index;
    logic [FIELD_W-1:0]  message_length;
    logic                last;
  } result_t;

endpackage

/* design/diameter_stream_deframer.sv */
// Channel   Direction  Handshake          Payload
// in_       input      in_valid/in_stall  in_data_byte[7:0], in_closed
// out_      output     out_valid/out_stall out_kind, out_header_word, out_body_byte,
//                                          out_byte_index, out_message_length, out_last
// cfg_      input      cfg_we             cfg_index, cfg_wdata[23:0]
//
// One input beat is accepted per cycle while in_stall is low. Its result goes
// to the output register, or to the skid register when the output is held; the
// deframing state updates in the accept cycle. A skid register behind the
// output register absorbs one result while out_stall is high; in_stall rises
// only when that skid register is full. Synchronous active-low reset clears
// the framing state and both stage valid flags, and loads the default length limits.
module diameter_stream_deframer #(
  parameter int unsigned LENGTH_BITS = dsd_pkg::LENGTH_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // Input channel.
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_closed,
  // Result channel.
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_kind,
  output logic [31:0] out_header_word,
  output logic [7:0]  out_body_byte,
  output logic [23:0] out_byte_index,
  output logic [23:0] out_message_length,
  output logic        out_last,
  // Configuration port.
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [23:0] cfg_wdata
);

  localparam logic [dsd_pkg::FIELD_W-1:0] LEN_MASK =
    dsd_pkg::FIELD_W'((33'd1 << LENGTH_BITS) - 33'd1);

  // Configuration registers.
  logic [23:0] min_length_r;
  logic [23:0] max_length_r;

  // Framing state.
  logic        in_body_r, in_body_nxt;
  logic [31:0] header_shift_r, header_shift_nxt;
  logic [1:0]  header_count_r, header_count_nxt;
  logic [23:0] bytes_seen_r, bytes_seen_nxt;
  logic [23:0] total_length_r, total_length_nxt;

  // Output register and skid register.
  dsd_pkg::result_t out_r, out_nxt;
  dsd_pkg::result_t skid_r, skid_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             skid_valid_r, skid_valid_nxt;

  // Result of the beat being accepted.
  dsd_pkg::result_t res;
  logic             res_valid;

  logic        in_fire;
  logic        out_fire;
  logic [31:0] shifted;
  logic [23:0] len_w;
  logic [24:0] idx_inc;
  logic        body_done;

  assign in_stall = skid_valid_r;
  assign in_fire  = in_valid && !skid_valid_r;
  assign out_fire = out_valid_r && !out_stall;

  assign shifted   = {header_shift_r[23:0], in_data_byte};
  assign len_w     = shifted[23:0] & LEN_MASK;
  assign idx_inc   = {1'b0, bytes_seen_r} + 25'd1;
  assign body_done = idx_inc >= {1'b0, total_length_r};

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_length_r <= dsd_pkg::MIN_LENGTH_RST;
      max_length_r <= dsd_pkg::MAX_LENGTH_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        dsd_pkg::CFG_MIN_LENGTH: min_length_r <= cfg_wdata;
        dsd_pkg::CFG_MAX_LENGTH: max_length_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Framing: header hunting, length check and body counting.
  always_comb begin
    in_body_nxt      = in_body_r;
    header_shift_nxt = header_shift_r;
    header_count_nxt = header_count_r;
    bytes_seen_nxt   = bytes_seen_r;
    total_length_nxt = total_length_r;
    res_valid        = 1'b0;
    res              = '0;

    if (in_fire) begin
      if (in_closed) begin
        // Connection closed: report and drop all framing state.
        in_body_nxt      = 1'b0;
        header_shift_nxt = '0;
        header_count_nxt = '0;
        bytes_seen_nxt   = '0;
        total_length_nxt = '0;
        res_valid        = 1'b1;
        res.kind         = dsd_pkg::KIND_CLOSED;
      end else if (!in_body_r) begin
        header_shift_nxt = shifted;
        header_count_nxt = header_count_r + 2'd1;
        if (header_count_r == 2'd3) begin
          res_valid          = 1'b1;
          res.header_word    = shifted;
          res.byte_index     = dsd_pkg::HEADER_LAST;
          res.message_length = len_w;
          if (len_w < min_length_r || len_w > max_length_r) begin
            // Bad length: report and restart hunting at the next byte.
            res.kind         = dsd_pkg::KIND_ERROR;
            header_shift_nxt = '0;
            header_count_nxt = '0;
            bytes_seen_nxt   = '0;
            total_length_nxt = '0;
          end else if (len_w <= dsd_pkg::HEADER_BYTES) begin
            // The header alone completes the message.
            res.kind         = dsd_pkg::KIND_HEADER;
            res.last         = 1'b1;
            header_shift_nxt = '0;
            header_count_nxt = '0;
            bytes_seen_nxt   = '0;
            total_length_nxt = '0;
          end else begin
            res.kind         = dsd_pkg::KIND_HEADER;
            in_body_nxt      = 1'b1;
            bytes_seen_nxt   = dsd_pkg::HEADER_BYTES;
            total_length_nxt = len_w;
          end
        end
      end else begin
        // Body byte with its position in the message.
        res_valid          = 1'b1;
        res.kind           = dsd_pkg::KIND_BODY;
        res.header_word    = header_shift_r;
        res.body_byte      = in_data_byte;
        res.byte_index     = bytes_seen_r;
        res.message_length = total_length_r;
        res.last           = body_done;
        if (body_done) begin
          in_body_nxt      = 1'b0;
          header_shift_nxt = '0;
          header_count_nxt = '0;
          bytes_seen_nxt   = '0;
          total_length_nxt = '0;
        end else begin
          bytes_seen_nxt = idx_inc[23:0];
        end
      end
    end
  end

  // Output register with a skid stage behind it.
  always_comb begin
    out_nxt        = out_r;
    skid_nxt       = skid_r;
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;

    if (out_fire) begin
      out_valid_nxt = 1'b0;
    end
    if (skid_valid_r) begin
      // Skid holds the older beat; move it up once the output drains.
      if (out_fire) begin
        out_nxt        = skid_r;
        out_valid_nxt  = 1'b1;
        skid_valid_nxt = 1'b0;
      end
    end else if (res_valid) begin
      if (!out_valid_r || out_fire) begin
        out_nxt       = res;
        out_valid_nxt = 1'b1;
      end else begin
        skid_nxt       = res;
        skid_valid_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_body_r      <= 1'b0;
      header_shift_r <= '0;
      header_count_r <= '0;
      bytes_seen_r   <= '0;
      total_length_r <= '0;
      out_valid_r    <= 1'b0;
      skid_valid_r   <= 1'b0;
    end else begin
      in_body_r      <= in_body_nxt;
      header_shift_r <= header_shift_nxt;
      header_count_r <= header_count_nxt;
      bytes_seen_r   <= bytes_seen_nxt;
      total_length_r <= total_length_nxt;
      out_valid_r    <= out_valid_nxt;
      skid_valid_r   <= skid_valid_nxt;
    end
  end

  // Payload stages need no reset.
  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_kind           = out_r.kind;
  assign out_header_word    = out_r.header_word;
  assign out_body_byte      = out_r.body_byte;
  assign out_byte_index     = out_r.byte_index;
  assign out_message_length = out_r.message_length;
  assign out_last           = out_r.last;

endmodule
